>>> src/tdpt_pkg.sv
// shared types and constants for the trial-division prime test
package tdpt_pkg;

  localparam int DEFAULT_VALUE_BITS = 32;
  // first trial divisor, also the smallest prime
  localparam int TRIAL_START = 2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_START,
    ST_DIV,
    ST_FINISH
  } tdpt_state_t;

  typedef struct packed {
    logic load;       // capture candidate, reset divisor
    logic div_start;  // begin a division n / d
    logic div_step;   // one restoring division step
    logic d_inc;      // move to next divisor
    logic decide;     // store the pending answer
    logic res_val;    // answer to store on decide
    logic publish;    // move pending answer into output register
  } tdpt_cmd_t;

  typedef struct packed {
    logic reject;      // negative, zero or one
    logic div_done;    // all quotient bits produced
    logic bound_over;  // d > n / d, no more divisors to try
    logic rem_zero;    // n % d == 0
  } tdpt_status_t;

endpackage

>>> src/tdpt_dpath.sv
// datapath: candidate and divisor registers, bit-serial restoring divider, result registers
module tdpt_dpath import tdpt_pkg::*; #(
  parameter int VALUE_BITS = DEFAULT_VALUE_BITS
) (
  input  logic                  clk,
  input  logic [VALUE_BITS-1:0] candidate,
  input  tdpt_cmd_t             cmd,
  output tdpt_status_t          status,
  output logic                  prime_flag
);

  localparam int CNT_W = $clog2(VALUE_BITS + 1);

  logic [VALUE_BITS-1:0] n_reg;
  logic [VALUE_BITS-1:0] d_reg;
  logic [VALUE_BITS-1:0] rem;
  logic [VALUE_BITS-1:0] quo;
  logic [CNT_W-1:0]      cnt;
  logic                  res;
  logic                  flag;

  logic [VALUE_BITS:0]   rem_sh;
  logic [VALUE_BITS:0]   diff;
  logic                  ge;

  // remainder stays below d, so the shifted value is below 2d
  assign rem_sh = {rem, quo[VALUE_BITS-1]};
  assign diff   = rem_sh - {1'b0, d_reg};
  assign ge     = ~diff[VALUE_BITS];

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      n_reg <= candidate;
      d_reg <= VALUE_BITS'(TRIAL_START);
    end else if (cmd.d_inc) begin
      d_reg <= d_reg + VALUE_BITS'(1);
    end
    if (cmd.div_start) begin
      rem <= '0;
      quo <= n_reg;
      cnt <= CNT_W'(VALUE_BITS);
    end else if (cmd.div_step) begin
      rem <= ge ? diff[VALUE_BITS-1:0] : rem_sh[VALUE_BITS-1:0];
      quo <= {quo[VALUE_BITS-2:0], ge};
      cnt <= cnt - CNT_W'(1);
    end
    if (cmd.decide) begin
      res <= cmd.res_val;
    end
    if (cmd.publish) begin
      flag <= res;
    end
  end

  always_comb begin
    status.reject     = n_reg[VALUE_BITS-1] || (n_reg < VALUE_BITS'(TRIAL_START));
    status.div_done   = (cnt == '0);
    status.bound_over = (d_reg > quo);
    status.rem_zero   = (rem == '0);
  end

  assign prime_flag = flag;

endmodule

>>> src/tdpt_ctrl.sv
// controller: sequences the trial divisions and owns the handshakes
module tdpt_ctrl import tdpt_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_ready,
  output logic         out_valid,
  input  logic         out_ready,
  input  tdpt_status_t status,
  output tdpt_cmd_t    cmd,
  output tdpt_state_t  state
);

  tdpt_state_t state_next;
  logic        out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_START;
        end
      end
      ST_START: begin
        if (status.reject) begin
          cmd.decide  = 1'b1;
          cmd.res_val = 1'b0;
          state_next  = ST_FINISH;
        end else begin
          cmd.div_start = 1'b1;
          state_next    = ST_DIV;
        end
      end
      ST_DIV: begin
        if (!status.div_done) begin
          cmd.div_step = 1'b1;
        end else if (status.bound_over) begin
          cmd.decide  = 1'b1;
          cmd.res_val = 1'b1;
          state_next  = ST_FINISH;
        end else if (status.rem_zero) begin
          cmd.decide  = 1'b1;
          cmd.res_val = 1'b0;
          state_next  = ST_FINISH;
        end else begin
          cmd.d_inc  = 1'b1;
          state_next = ST_START;
        end
      end
      ST_FINISH: begin
        // wait until the output register is free
        if (!out_valid || out_ready) begin
          cmd.publish = 1'b1;
          state_next  = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.publish) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

endmodule

>>> src/trial_division_prime_test.sv
// top level of the trial-division prime test
// Each request carries one signed candidate; the block answers 1 if it is prime and 0
// otherwise (negative, zero and one give 0). Divisors d = 2, 3, ... are tried while
// d <= n / d, using one bit-serial restoring divider that yields quotient and remainder
// together. Each trial divisor takes a setup step, one quotient bit per cycle and a
// decision step, so the work per item grows with its smallest divisor, or with sqrt(n)
// for a prime n. Non-positive candidates and one are rejected before any division.
// Items are worked one at a time; a new request is taken while the previous answer
// still sits in the output register.
module trial_division_prime_test import tdpt_pkg::*; #(
  parameter int VALUE_BITS = DEFAULT_VALUE_BITS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [VALUE_BITS-1:0] candidate,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  prime_flag
);

  tdpt_cmd_t    cmd;
  tdpt_status_t status;
  tdpt_state_t  state;

  tdpt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd),
    .state     (state)
  );

  tdpt_dpath #(
    .VALUE_BITS (VALUE_BITS)
  ) u_dpath (
    .clk        (clk),
    .candidate  (candidate),
    .cmd        (cmd),
    .status     (status),
    .prime_flag (prime_flag)
  );

  // an accepted request always goes on to its first divisor setup
  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state == ST_START))
    else $error("accepted request did not start");

  // prime is only declared once the divisor bound is passed
  a_prime_needs_bound: assert property (@(posedge clk) disable iff (rst)
    (cmd.decide && cmd.res_val) |-> status.bound_over)
    else $error("prime declared before bound reached");

  // a new result never lands on one that is still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.publish |-> (!out_valid || out_ready))
    else $error("result overwritten");

  // no division step once all quotient bits are done
  a_step_bounded: assert property (@(posedge clk) disable iff (rst)
    cmd.div_step |-> !status.div_done)
    else $error("divider stepped past last bit");

endmodule

>>> verif/tb_trial_division_prime_test.sv
// self-checking testbench for the trial-division prime test
`timescale 1ns / 100ps

module tb_trial_division_prime_test import tdpt_pkg::*; ();

  localparam int VB = DEFAULT_VALUE_BITS;
  localparam int HOLD_CYCLES = 120;
  localparam int ITEMS_PER_MIX = 24;
  localparam int TAIL_CYCLES = 50;

  typedef logic [VB-1:0] value_t;

  typedef struct {
    value_t value;
    bit     typed;  // flag below is taken as written
    logic   flag;
  } directed_row_t;

  logic   clk;
  logic   rst;
  logic   in_valid;
  logic   in_ready;
  value_t candidate;
  logic   out_valid;
  logic   out_ready;
  logic   prime_flag;

  logic pending_flags[$];
  int   error_count;
  int   answers_checked;
  int   primes_seen;
  int   send_idle_pct;
  int   recv_idle_pct;
  int   hold_req;

  trial_division_prime_test #(
    .VALUE_BITS(VB)
  ) u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .candidate (candidate),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .prime_flag(prime_flag)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("== FAIL ==");
    $finish;
  end

  function automatic logic predict_flag(value_t v);
    int unsigned n;
    int unsigned d;
    if (v[VB-1]) begin
      return 1'b0;
    end
    n = v;
    if (n < TRIAL_START) begin
      return 1'b0;
    end
    for (d = TRIAL_START; d <= n / d; d++) begin
      if (n % d == 0) begin
        return 1'b0;
      end
    end
    return 1'b1;
  endfunction

  // mostly cheap values: a random prime near the top of the range would need a trial
  // division by every divisor up to its square root, so large positives always carry a small factor
  function automatic value_t random_candidate();
    int unsigned pick;
    int unsigned p;
    int unsigned q;
    pick = $urandom_range(99);
    if (pick < 15) begin
      return value_t'($urandom()) | (value_t'(1) << (VB - 1));
    end else if (pick < 23) begin
      return value_t'($urandom_range(3));
    end else if (pick < 55) begin
      return value_t'($urandom_range(4095, 2));
    end else if (pick < 80) begin
      case ($urandom_range(5))
        0: p = 2;
        1: p = 3;
        2: p = 5;
        3: p = 7;
        4: p = 11;
        default: p = 13;
      endcase
      q = $urandom_range(32'h7FFF_FFFF / p, 1);
      return value_t'(q * p);
    end else if (pick < 92) begin
      return value_t'($urandom_range(65535, 4096));
    end else begin
      // squares hit the bound exactly when the root is prime
      q = $urandom_range(300, 2);
      return value_t'(q * q);
    end
  endfunction

  task automatic send_request(value_t v, logic flag);
    int gap;
    gap = 0;
    while (gap < 20 && $urandom_range(99) < send_idle_pct) begin
      gap++;
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    candidate <= v;
    do @(posedge clk); while (!in_ready);
    pending_flags.push_back(flag);
  endtask

  // answer checker and receiver stalls
  initial begin : receiver
    int hold_left;
    int hold_seen;
    logic want;
    hold_left = 0;
    hold_seen = 0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && out_ready) begin
        if (pending_flags.size() == 0) begin
          $display("%0t: unexpected answer %0b with no request pending", $time, prime_flag);
          error_count++;
        end else begin
          want = pending_flags.pop_front();
          if (prime_flag !== want) begin
            $display("%0t: prime_flag mismatch: expected %0b, actual %0b",
                     $time, want, prime_flag);
            error_count++;
          end
          answers_checked++;
          if (want) begin
            primes_seen++;
          end
        end
      end
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  initial begin : stimulus
    directed_row_t rows[$];
    value_t v;
    int mix;
    int i;

    rst             = 1'b1;
    in_valid        = 1'b0;
    candidate       = '0;
    out_ready       = 1'b0;
    error_count     = 0;
    answers_checked = 0;
    primes_seen     = 0;
    hold_req        = 0;
    send_idle_pct   = 18;
    recv_idle_pct   = 57;

    rows = '{
      '{value_t'(0),            1'b1, 1'b0},
      '{value_t'(1),            1'b1, 1'b0},
      '{value_t'(2),            1'b1, 1'b1},
      '{value_t'(3),            1'b1, 1'b1},
      '{value_t'(4),            1'b1, 1'b0},
      '{value_t'(-1),           1'b1, 1'b0},
      '{value_t'(-2),           1'b1, 1'b0},
      '{value_t'(-7),           1'b1, 1'b0},
      '{32'h8000_0000,          1'b1, 1'b0},
      '{32'hFFFF_FFFF,          1'b1, 1'b0},
      '{32'hD555_5555,          1'b1, 1'b0},
      '{value_t'(9),            1'b0, 1'b0},
      '{value_t'(25),           1'b0, 1'b0},
      '{value_t'(49),           1'b0, 1'b0},
      '{value_t'(97),           1'b0, 1'b0},
      '{value_t'(1009 * 1013),  1'b0, 1'b0},
      '{value_t'(65521),        1'b0, 1'b0},
      '{value_t'(65535),        1'b0, 1'b0},
      '{32'h2AAA_AAAA,          1'b0, 1'b0},
      '{32'h5555_5555,          1'b0, 1'b0},
      '{32'h7FFF_FFFE,          1'b0, 1'b0},
      '{32'h7FFF_FFFF,          1'b0, 1'b0}
    };

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (rows[r]) begin
      send_request(rows[r].value, rows[r].typed ? rows[r].flag : predict_flag(rows[r].value));
    end

    // stall the answer side while requests keep coming, so the block backs up
    hold_req <= hold_req + 1;
    for (i = 0; i < 8; i++) begin
      v = (i % 2 == 0) ? value_t'(-i - 1) : value_t'(i);
      send_request(v, predict_flag(v));
    end

    for (mix = 0; mix < 3; mix++) begin
      case (mix)
        0: begin
          send_idle_pct = 18;
          recv_idle_pct = 57;
        end
        1: begin
          send_idle_pct = 57;
          recv_idle_pct = 18;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      for (i = 0; i < ITEMS_PER_MIX; i++) begin
        v = random_candidate();
        send_request(v, predict_flag(v));
      end
    end
    in_valid <= 1'b0;

    while (pending_flags.size() != 0) begin
      @(posedge clk);
    end
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("checked %0d answers, %0d of them prime: directed edges, a backed-up output,",
             answers_checked, primes_seen);
    $display("then random candidates under three sender/receiver idle mixes");
    if (error_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
